// ----- rtl/cobeq_pkg.sv -----
// Shared types, widths and constants of the cascaded one-pole band equalizer.
// Used by the sequencer, multiplier and top module through scoped names; depends on nothing.
package cobeq_pkg;

   localparam int BANDS_DEF    = 4;
   localparam int CHANNELS_DEF = 8;
   localparam int MAX_BANDS    = 4;
   localparam int BAND_W       = 2;

   localparam int CH_W       = 3;
   localparam int SAMPLE_W   = 24;
   localparam int FIELD_W    = 16;
   localparam int ENERGY_W   = 28;
   localparam int RES_W      = 32;
   localparam int ACC_W      = 48;
   localparam int MA_W       = 33;
   localparam int MB_W       = 17;
   localparam int PROD_W     = 50;
   localparam int LO_W       = 17;
   localparam int CSR_W      = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_W      = 32;

   localparam logic [FIELD_W-1:0] UNITY = 16'd4096;

   localparam logic [CSR_ADDR_W-1:0] REG_COEF = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAIN = 2'd2;

   localparam logic [CSR_W-1:0]   COEF_RESET = 64'h0;
   localparam logic [CSR_W-1:0]   GAIN_RESET = 64'h1000_1000_1000_1000;
   localparam logic [FIELD_W-1:0] MAIN_RESET = 16'h1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_MUL,
      ST_UPD,
      ST_GAIN,
      ST_GSUM,
      ST_MLO,
      ST_MHI,
      ST_SAT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_COEF,
      OP_GAIN,
      OP_LO,
      OP_HI
   } op_type;

   typedef struct packed {
      state_type         st;
      logic [BAND_W-1:0] band;
      logic [BAND_W-1:0] rd_band;
      logic              idle;
      logic              mem_rd;
      logic              mem_wr;
      op_type            op;
      logic              mul_en;
      logic              push_u;
      logic              rot_u;
      logic              acc_init;
      logic              acc_add;
      logic              lo_cap;
      logic              fin;
   } ctrl_type;

   // Picks one 16-bit slot out of a packed 64-bit register.
   function automatic logic [FIELD_W-1:0] field16(input logic [CSR_W-1:0] pack,
                                                  input logic [BAND_W-1:0] idx);
      field16 = pack[idx*FIELD_W +: FIELD_W];
   endfunction

endpackage

// ----- rtl/cobeq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the per-channel band energy states; no package dependency.
module cobeq_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

// ----- rtl/cobeq_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on cobeq_pkg for operand and product widths.
module cobeq_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [cobeq_pkg::MA_W-1:0]    a,
   input  logic signed [cobeq_pkg::MB_W-1:0]    b,
   output logic signed [cobeq_pkg::PROD_W-1:0]  prod_ff
);

   logic signed [cobeq_pkg::PROD_W-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- rtl/cobeq_seq.sv -----
// Sequencer that steps one sample through the band updates and output sums.
// Depends on cobeq_pkg for the state, operation and control types.
module cobeq_seq #(
   parameter int BANDS = cobeq_pkg::BANDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                bypass,
   output cobeq_pkg::ctrl_type ctrl
);

   cobeq_pkg::state_type             state_ff, state_in;
   logic [cobeq_pkg::BAND_W-1:0]     band_ff, band_in;
   logic                             last;

   assign last = (band_ff == cobeq_pkg::BAND_W'(BANDS - 1));

   // Next state and band counter.
   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      unique case (state_ff)
         cobeq_pkg::ST_IDLE: begin
            band_in = '0;
            if (req_fire && !bypass) begin
               state_in = cobeq_pkg::ST_RD;
            end
         end
         cobeq_pkg::ST_RD:   state_in = cobeq_pkg::ST_MUL;
         cobeq_pkg::ST_MUL:  state_in = cobeq_pkg::ST_UPD;
         cobeq_pkg::ST_UPD: begin
            if (last) begin
               state_in = cobeq_pkg::ST_GAIN;
               band_in  = '0;
            end else begin
               state_in = cobeq_pkg::ST_MUL;
               band_in  = band_ff + 1'b1;
            end
         end
         cobeq_pkg::ST_GAIN: begin
            band_in = band_ff + 1'b1;
            if (last) begin
               state_in = cobeq_pkg::ST_GSUM;
            end
         end
         cobeq_pkg::ST_GSUM: state_in = cobeq_pkg::ST_MLO;
         cobeq_pkg::ST_MLO:  state_in = cobeq_pkg::ST_MHI;
         cobeq_pkg::ST_MHI:  state_in = cobeq_pkg::ST_SAT;
         cobeq_pkg::ST_SAT:  state_in = cobeq_pkg::ST_IDLE;
         default:            state_in = cobeq_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl          = '0;
      ctrl.st       = state_ff;
      ctrl.band     = band_ff;
      ctrl.rd_band  = band_ff;
      ctrl.op       = cobeq_pkg::OP_NONE;
      unique case (state_ff)
         cobeq_pkg::ST_IDLE: ctrl.idle = 1'b1;
         cobeq_pkg::ST_RD:   ctrl.mem_rd = 1'b1;
         cobeq_pkg::ST_MUL: begin
            ctrl.op     = cobeq_pkg::OP_COEF;
            ctrl.mul_en = 1'b1;
            ctrl.push_u = 1'b1;
         end
         cobeq_pkg::ST_UPD: begin
            ctrl.mem_wr   = 1'b1;
            ctrl.mem_rd   = !last;
            ctrl.rd_band  = band_ff + 1'b1;
            ctrl.acc_init = last;
         end
         cobeq_pkg::ST_GAIN: begin
            ctrl.op      = cobeq_pkg::OP_GAIN;
            ctrl.mul_en  = 1'b1;
            ctrl.rot_u   = 1'b1;
            ctrl.acc_add = (band_ff != '0);
         end
         cobeq_pkg::ST_GSUM: ctrl.acc_add = 1'b1;
         cobeq_pkg::ST_MLO: begin
            ctrl.op     = cobeq_pkg::OP_LO;
            ctrl.mul_en = 1'b1;
         end
         cobeq_pkg::ST_MHI: begin
            ctrl.op     = cobeq_pkg::OP_HI;
            ctrl.mul_en = 1'b1;
            ctrl.lo_cap = 1'b1;
         end
         cobeq_pkg::ST_SAT:  ctrl.fin = 1'b1;
         default:            ctrl.idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cobeq_pkg::ST_IDLE;
         band_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
      end
   end

endmodule

// ----- rtl/cascaded_onepole_band_equalizer.sv -----
// Top level of the cascaded one-pole band equalizer: registers, datapath, result stage.
// Depends on cobeq_pkg and instantiates cobeq_seq, cobeq_mul and cobeq_ram.
//
// Usage: samples arrive on the req_ stream (channel and signed 24-bit sample in
// req_tdata) and one result leaves on the rsp_ stream for every accepted item,
// in order. rsp_tuser is high when the sample was equalized and low when it was
// passed through unchanged (all gains at unity, or a channel number at or above
// CHANNELS). The csr_ port writes coefficient, gain and main gain registers; it
// is meant to be used only while no item is in flight.
// A passed-through item is written into the result register as it is accepted.
// An equalized item steps through a read of its first band state, a multiply
// and an update per band, a gain pass per band, the gain sum, the low and high
// main gain products and a saturation step before its result is registered;
// its products all come from the one shared 33x17 multiplier. The block takes
// no new item until that result is registered, so passed-through items run at
// one per cycle only while the receiver takes each result.
// The result sits in an output register, so a new item is accepted in the same
// cycle that a waiting result is taken; while the receiver stalls, the block
// holds its result and accepts nothing more. Synchronous reset restores the
// register defaults and marks every band state as zero at once through one
// valid bit per entry, so no clearing pass is needed.
module cascaded_onepole_band_equalizer #(
   parameter int BANDS    = cobeq_pkg::BANDS_DEF,
   parameter int CHANNELS = cobeq_pkg::CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream. req_tdata: [2:0] channel, [26:3] sample_in, [31:27] zero.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cobeq_pkg::REQ_W-1:0]          req_tdata,
   // Result stream. rsp_tdata: [23:0] sample_out. rsp_tuser: [0] filtered.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cobeq_pkg::SAMPLE_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,
   // Register write port.
   input  logic                                 csr_we,
   input  logic [cobeq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cobeq_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int DEPTH = CHANNELS * BANDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int E_W   = cobeq_pkg::ENERGY_W;
   localparam int S_W   = cobeq_pkg::SAMPLE_W;
   localparam int P_W   = cobeq_pkg::PROD_W;
   localparam int A_W   = cobeq_pkg::ACC_W;
   localparam int R_W   = cobeq_pkg::RES_W;

   // Configuration registers.
   logic [cobeq_pkg::CSR_W-1:0]   coef_ff, gain_ff;
   logic [cobeq_pkg::FIELD_W-1:0] main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= cobeq_pkg::COEF_RESET;
         gain_ff <= cobeq_pkg::GAIN_RESET;
         main_ff <= cobeq_pkg::MAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            cobeq_pkg::REG_COEF: coef_ff <= csr_wdata;
            cobeq_pkg::REG_GAIN: gain_ff <= csr_wdata;
            cobeq_pkg::REG_MAIN: main_ff <= csr_wdata[cobeq_pkg::FIELD_W-1:0];
            default:             main_ff <= main_ff;
         endcase
      end
   end

   // Request decode and bypass decision.
   logic [cobeq_pkg::CH_W-1:0]  req_ch;
   logic signed [S_W-1:0]       req_sample;
   logic                        unity;
   logic                        bypass;
   logic                        req_fire;
   logic                        rsp_valid_ff;
   cobeq_pkg::ctrl_type         ctrl;

   assign req_ch     = req_tdata[cobeq_pkg::CH_W-1:0];
   assign req_sample = signed'(req_tdata[cobeq_pkg::CH_W +: S_W]);

   // Slots at or above BANDS never take part in the unity check.
   always_comb begin
      unity = (main_ff == cobeq_pkg::UNITY);
      for (int b = 0; b < cobeq_pkg::MAX_BANDS; b++) begin
         if (b < BANDS &&
             cobeq_pkg::field16(gain_ff, cobeq_pkg::BAND_W'(b)) != cobeq_pkg::UNITY) begin
            unity = 1'b0;
         end
      end
   end

   assign bypass     = unity || (32'(req_ch) >= CHANNELS);
   assign req_tready = ctrl.idle && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   cobeq_seq #(
      .BANDS (BANDS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .bypass   (bypass),
      .ctrl     (ctrl)
   );

   // Band state memory with one valid bit per entry; an entry never written
   // since reset reads as zero.
   logic [cobeq_pkg::CH_W-1:0] ch_ff;
   logic [AW-1:0]              raddr, waddr;
   logic [E_W-1:0]             mem_rdata;
   logic [E_W-1:0]             e_new;
   logic [DEPTH-1:0]           valid_ff;
   logic                       rd_valid_ff;

   assign raddr = AW'(32'(ch_ff) * BANDS + 32'(ctrl.rd_band));
   assign waddr = AW'(32'(ch_ff) * BANDS + 32'(ctrl.band));

   cobeq_ram #(
      .WIDTH (E_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock    (clock),
      .we       (ctrl.mem_wr),
      .waddr    (waddr),
      .wdata    (e_new),
      .re       (ctrl.mem_rd),
      .raddr    (raddr),
      .rdata_ff (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.mem_wr) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_rd) begin
         rd_valid_ff <= valid_ff[raddr];
      end
   end

   // Datapath registers.
   logic signed [R_W-1:0]      residue_ff;
   logic signed [E_W-1:0]      e_ff;
   logic signed [E_W-1:0]      u_ff [BANDS];
   logic signed [A_W-1:0]      acc_ff;
   logic [cobeq_pkg::LO_W-1:0] lo_ff;
   logic signed [P_W-1:0]      prod_ff;

   logic signed [E_W-1:0]      e_cur;
   logic signed [R_W-1:0]      diff;

   assign e_cur = rd_valid_ff ? signed'(mem_rdata) : '0;
   assign diff  = residue_ff - R_W'(e_cur);

   // Operand selection for the shared multiplier. The main gain product is
   // split into the low 24 unsigned bits and the high signed part of acc.
   logic signed [cobeq_pkg::MA_W-1:0] mul_a;
   logic signed [cobeq_pkg::MB_W-1:0] mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         cobeq_pkg::OP_COEF: begin
            mul_a = cobeq_pkg::MA_W'(diff);
            mul_b = signed'({1'b0, cobeq_pkg::field16(coef_ff, ctrl.band)});
         end
         cobeq_pkg::OP_GAIN: begin
            mul_a = cobeq_pkg::MA_W'(u_ff[0]);
            mul_b = signed'({1'b0, cobeq_pkg::field16(gain_ff, ctrl.band)});
         end
         cobeq_pkg::OP_LO: begin
            mul_a = signed'({{(cobeq_pkg::MA_W-24){1'b0}}, acc_ff[23:0]});
            mul_b = signed'({1'b0, main_ff});
         end
         cobeq_pkg::OP_HI: begin
            mul_a = cobeq_pkg::MA_W'(signed'(acc_ff[A_W-1:24]));
            mul_b = signed'({1'b0, main_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   cobeq_mul u_mul (
      .clock   (clock),
      .en      (ctrl.mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   // State update: E + round(diff*coef / 2^15), saturated to 28 bits.
   logic signed [P_W-1:0] step;
   logic signed [P_W-1:0] e_sum;
   logic                  e_fits;

   assign step   = (prod_ff + P_W'(1 <<< 14)) >>> 15;
   assign e_sum  = P_W'(e_ff) + step;
   assign e_fits = (&e_sum[P_W-1:E_W-1]) || !(|e_sum[P_W-1:E_W-1]);
   assign e_new  = e_fits ? e_sum[E_W-1:0] :
                   (e_sum[P_W-1] ? {1'b1, {(E_W-1){1'b0}}} : {1'b0, {(E_W-1){1'b1}}});

   // Output: high product plus the rounded carry out of the low product.
   logic [40:0]           lo_sum;
   logic signed [P_W-1:0] y_sum;
   logic                  y_fits;
   logic [S_W-1:0]        y_sat;

   assign lo_sum = prod_ff[40:0] + 41'(1 << 23);
   assign y_sum  = prod_ff + signed'({{(P_W-cobeq_pkg::LO_W){1'b0}}, lo_ff});
   assign y_fits = (&y_sum[P_W-1:S_W-1]) || !(|y_sum[P_W-1:S_W-1]);
   assign y_sat  = y_fits ? y_sum[S_W-1:0] :
                   (y_sum[P_W-1] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}});

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff      <= req_ch;
         residue_ff <= R_W'(req_sample);
      end
      if (ctrl.push_u) begin
         e_ff       <= e_cur;
         residue_ff <= diff;
      end
      // Band outputs line up in order; the gain pass rotates them back round.
      if (ctrl.push_u || ctrl.rot_u) begin
         for (int i = 0; i < BANDS - 1; i++) begin
            u_ff[i] <= u_ff[i+1];
         end
         u_ff[BANDS-1] <= ctrl.push_u ? e_cur : u_ff[0];
      end
      if (ctrl.acc_init) begin
         acc_ff <= A_W'(residue_ff) <<< 12;
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + A_W'(prod_ff);
      end
      if (ctrl.lo_cap) begin
         lo_ff <= lo_sum[40:24];
      end
   end

   // Result register.
   logic [S_W-1:0] rsp_data_ff;
   logic           rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((req_fire && bypass) || ctrl.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && bypass) begin
         rsp_data_ff <= req_sample;
         rsp_user_ff <= 1'b0;
      end else if (ctrl.fin) begin
         rsp_data_ff <= y_sat;
         rsp_user_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // Band state is only ever written for a channel that exists.
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_wr |-> (32'(ch_ff) < CHANNELS))
      else $error("band state written for an out-of-range channel");

   // An item that is equalized never produces its result the next cycle.
   a_eq_not_early: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !bypass) |=> !rsp_tvalid)
      else $error("equalized result appeared too early");

   // A passed-through item is registered straight into the result, marked as not filtered.
   a_bypass_next: assert property (@(posedge clock) disable iff (reset)
      (req_fire && bypass) |=> (rsp_tvalid && !rsp_tuser))
      else $error("pass-through result missing or mismarked");

   // A new result only appears once the sequencer is back at rest.
   a_rise_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ctrl.idle)
      else $error("result raised while the sequencer is busy");
`endif

endmodule

// ----- dv/cascaded_onepole_band_equalizer_tb.sv -----
// Self-checking testbench for the cascaded one-pole band equalizer.
// Needs only cobeq_pkg and the cascaded_onepole_band_equalizer RTL; it reads no files.
`timescale 1ns / 100ps

module cascaded_onepole_band_equalizer_tb;

   localparam int BANDS        = cobeq_pkg::BANDS_DEF;
   localparam int CHANNELS     = cobeq_pkg::CHANNELS_DEF;
   localparam int STALL_LIMIT  = 5000;   // cycles with no item moving on either stream
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS  = 128;

   // Index 3 decodes to no register; writes there must leave everything alone.
   localparam logic [cobeq_pkg::CSR_ADDR_W-1:0] REG_SPARE = 2'd3;

   localparam longint ENERGY_MAX = 64'sd134217727;
   localparam longint ENERGY_MIN = -64'sd134217728;
   localparam longint SAMPLE_MAX = 64'sd8388607;
   localparam longint SAMPLE_MIN = -64'sd8388608;

   // How the receiver decides to take results during one stretch of cycles.
   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_SPARSE,
      RDY_COIN,
      RDY_PERIODIC
   } ready_mode_type;

   typedef struct {
      logic [cobeq_pkg::SAMPLE_W-1:0] sample;
      logic                           filtered;
   } eq_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // [2:0] channel, [26:3] sample_in, [31:27] zero
   logic [cobeq_pkg::REQ_W-1:0]       req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [cobeq_pkg::SAMPLE_W-1:0]    rsp_tdata;         // [23:0] sample_out
   logic                              rsp_tuser;         // [0] filtered
   logic                              csr_we = 1'b0;
   logic [cobeq_pkg::CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [cobeq_pkg::CSR_W-1:0]       csr_wdata = '0;

   // Shadow copy of the register file and of the per-channel band energies.
   logic [cobeq_pkg::CSR_W-1:0]           coef_shadow = cobeq_pkg::COEF_RESET;
   logic [cobeq_pkg::CSR_W-1:0]           gain_shadow = cobeq_pkg::GAIN_RESET;
   logic [cobeq_pkg::FIELD_W-1:0]         main_shadow = cobeq_pkg::MAIN_RESET;
   logic signed [cobeq_pkg::ENERGY_W-1:0] energy_shadow [CHANNELS*BANDS];

   eq_result_type pending_samples [$];

   int burst_left    = 0;
   int samples_sent  = 0;
   int equalized_seen = 0;
   int passed_seen   = 0;
   int setting_count = 0;
   int mismatch_count = 0;
   int quiet_cycles  = 0;

   ready_mode_type ready_mode = RDY_ALWAYS;
   int             ready_hold = 0;
   int             ready_tick = 0;

   cascaded_onepole_band_equalizer #(
      .BANDS   (BANDS),
      .CHANNELS(CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Runs one sample through the band cascade of its channel and returns the
   // expected output. The channel's energies are advanced unless the sample
   // passes straight through.
   function automatic eq_result_type equalize_sample(
         input logic [cobeq_pkg::CH_W-1:0] ch,
         input logic signed [cobeq_pkg::SAMPLE_W-1:0] x);
      eq_result_type r;
      longint        band_out [BANDS];
      longint        residue, e, nudge, acc, y;
      int            b, idx;
      bit            all_unity;
      all_unity = (main_shadow == cobeq_pkg::UNITY);
      for (b = 0; b < BANDS; b++)
         if (gain_shadow[16*b +: 16] != cobeq_pkg::UNITY) all_unity = 0;
      if (all_unity || ch >= CHANNELS) begin
         r.sample   = x;
         r.filtered = 1'b0;
         return r;
      end
      // Each band reports its old energy, which is peeled off the residue; the
      // energy then chases the residue as it stood before the subtraction.
      residue = longint'(x);
      for (b = 0; b < BANDS; b++) begin
         idx         = int'(ch) * BANDS + b;
         e           = longint'(energy_shadow[idx]);
         nudge       = ((residue - e) * longint'(coef_shadow[16*b +: 16]) + 64'sd16384) >>> 15;
         band_out[b] = e;
         residue     = residue - e;
         energy_shadow[idx] = cobeq_pkg::ENERGY_W'(clamp_range(e + nudge, ENERGY_MIN,
                                                               ENERGY_MAX));
      end
      acc = residue * 64'sd4096;
      for (b = 0; b < BANDS; b++)
         acc = acc + band_out[b] * longint'(gain_shadow[16*b +: 16]);
      y = clamp_range((acc * longint'(main_shadow) + 64'sd8388608) >>> 24,
                      SAMPLE_MIN, SAMPLE_MAX);
      r.sample   = y[cobeq_pkg::SAMPLE_W-1:0];
      r.filtered = 1'b1;
      return r;
   endfunction

   // Audio-like samples mostly, with a good share of full-scale values so
   // that the energies and the output saturate often enough.
   function automatic logic signed [cobeq_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0:          return 24'sh7FFFFF;
         1:          return 24'sh800000;
         2:          return 24'sd0;
         3:          return -24'sd1;
         4, 5, 6, 7: return 24'($signed($urandom_range(0, 131071)) - 65536);
         default:    return 24'($urandom);
      endcase
   endfunction

   function automatic logic [cobeq_pkg::FIELD_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3, 4: return 16'($urandom_range(1, 8192));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [cobeq_pkg::FIELD_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return cobeq_pkg::UNITY;
         3, 4, 5: return 16'($urandom_range(2048, 8192));
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one item and returns at the clock edge where it was taken. The
   // sender runs in bursts; between bursts valid may drop for a random gap.
   task automatic send_sample(input logic [cobeq_pkg::CH_W-1:0] ch,
                              input logic signed [cobeq_pkg::SAMPLE_W-1:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, x, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_samples.push_back(equalize_sample(ch, x));
      samples_sent++;
      burst_left--;
   endtask

   // Stops offering items and waits until every expected result has been taken.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all three registers, plus a write to the unused index that must
   // have no effect, once the block has gone idle. The main gain write carries
   // random upper bits that the register has to drop.
   task automatic apply_settings(input logic [cobeq_pkg::CSR_W-1:0] coef,
                                 input logic [cobeq_pkg::CSR_W-1:0] gain,
                                 input logic [cobeq_pkg::FIELD_W-1:0] main);
      wait_drain();
      csr_we    <= 1'b1;
      csr_addr  <= cobeq_pkg::REG_COEF;
      csr_wdata <= coef;
      @(posedge clock);
      csr_addr  <= cobeq_pkg::REG_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_addr  <= cobeq_pkg::REG_MAIN;
      csr_wdata <= {16'($urandom), 32'($urandom), main};
      @(posedge clock);
      csr_addr  <= REG_SPARE;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we    <= 1'b0;
      coef_shadow = coef;
      gain_shadow = gain;
      main_shadow = main;
      setting_count++;
   endtask

   // With the reset gains every sample must come back untouched, on every
   // channel and at both ends of the range.
   task automatic test_pass_through();
      logic signed [cobeq_pkg::SAMPLE_W-1:0] values [8];
      int i;
      values = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'shFFFFFF,
                 24'sh000001, 24'sh555555, 24'shAAAAAA, 24'sh123456};
      for (i = 0; i < 8; i++)
         send_sample(3'(i), values[i]);
   endtask

   // Largest coefficients make each energy overshoot the residue, so
   // alternating full-scale samples drive the energies into saturation and
   // the maximum gains push the output into its clamp.
   task automatic test_saturation();
      int i;
      apply_settings({4{16'hFFFF}}, {4{16'hFFFF}}, 16'hFFFF);
      for (i = 0; i < 10; i++)
         send_sample(3'd7, (i % 2 == 0) ? 24'sh7FFFFF : 24'sh800000);
   endtask

   // Unity detection has to look at every gain: only the main gain off by
   // one, then only the last band gain off by one, then all gains at zero.
   task automatic test_unity_edges();
      apply_settings({4{16'h4000}}, {4{cobeq_pkg::UNITY}}, cobeq_pkg::UNITY + 16'd1);
      send_sample(3'd3, 24'sh400000);
      send_sample(3'd3, 24'shC00000);
      apply_settings({4{16'h4000}},
                     {cobeq_pkg::UNITY - 16'd1, cobeq_pkg::UNITY, cobeq_pkg::UNITY,
                      cobeq_pkg::UNITY},
                     cobeq_pkg::UNITY);
      send_sample(3'd3, 24'sh7FFFFF);
      send_sample(3'd3, 24'sh000100);
      apply_settings({4{16'h0100}}, 64'h0, 16'h0000);
      send_sample(3'd5, 24'sh7FFFFF);
   endtask

   // Random register settings, each followed by a run of random samples over
   // all channels. The first settings are fixed: all at maximum, all at zero,
   // and unity gains with random coefficients, which must not move any energy.
   task automatic test_random_phases();
      logic [cobeq_pkg::CSR_W-1:0]   coef, gain;
      logic [cobeq_pkg::FIELD_W-1:0] main;
      int ph, n;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         coef = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
         gain = {pick_gain(), pick_gain(), pick_gain(), pick_gain()};
         main = pick_gain();
         case (ph)
            0: begin
               coef = {4{16'hFFFF}};
               gain = {4{16'hFFFF}};
               main = 16'hFFFF;
            end
            1: begin
               coef = 64'h0;
               gain = 64'h0;
               main = 16'h0000;
            end
            2: begin
               gain = {4{cobeq_pkg::UNITY}};
               main = cobeq_pkg::UNITY;
            end
            default: begin
               if ($urandom_range(0, 5) == 0) begin
                  gain = {4{cobeq_pkg::UNITY}};
                  main = cobeq_pkg::UNITY;
               end
            end
         endcase
         apply_settings(coef, gain, main);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_sample(3'($urandom_range(0, CHANNELS - 1)), pick_sample());
      end
   endtask

   // The receiver picks a new behavior after each random hold: always ready,
   // mostly ready, a coin toss, or a fixed periodic stall pattern.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_hold = $urandom_range(32, 256);
      end else begin
         ready_hold--;
      end
      ready_tick++;
      case (ready_mode)
         RDY_ALWAYS:   rsp_tready <= 1'b1;
         RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) != 0);
         RDY_COIN:     rsp_tready <= ($urandom_range(0, 1) != 0);
         RDY_PERIODIC: rsp_tready <= ((ready_tick % 8) >= 3);
      endcase
   end

   // Every result taken is compared with the oldest expectation, field by field.
   always @(posedge clock) begin
      eq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual sample_out %h filtered %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (want.filtered) equalized_seen++;
            else passed_seen++;
            if (rsp_tdata !== want.sample) begin
               $display("%0t: sample_out mismatch: expected %h, actual %h",
                        $time, want.sample, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.filtered) begin
               $display("%0t: filtered mismatch: expected %b, actual %b",
                        $time, want.filtered, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither stream moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, pending_samples.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      foreach (energy_shadow[i]) energy_shadow[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_pass_through();
      test_saturation();
      test_unity_edges();
      test_random_phases();

      wait_drain();
      repeat (30) @(posedge clock);

      $display("Sent %0d samples over %0d register settings on %0d channels.",
               samples_sent, setting_count, CHANNELS);
      $display("Results checked: %0d equalized, %0d passed through, %0d mismatches.",
               equalized_seen, passed_seen, mismatch_count);
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
